@@ design/assert_macros.svh @@
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ design/trn_pkg.sv @@
// types and constants of the telnet receive negotiator
package trn_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       packet_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic       echo_on;
    logic       no_go_ahead;
  } out_word_t;

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_IAC,
    MODE_OPTION,
    MODE_SUB
  } mode_e;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_EOL   = 2'd1;
  localparam logic [1:0] KIND_ECHO  = 2'd2;
  localparam logic [1:0] KIND_REPLY = 2'd3;

  localparam logic [7:0] TN_NUL  = 8'd0;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_IAC  = 8'd255;

  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;

  // pending verb is held as the verb code minus WILL
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0]                  count;
    logic [MaxResults-1:0][1:0]  kind;
    logic [MaxResults-1:0][7:0]  value;
    logic                        echo_on;
    logic                        no_go_ahead;
  } bundle_t;

endpackage

@@ design/trn_step.sv @@
// negotiation state and the result words one received byte produces
module trn_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  trn_pkg::in_word_t data_i,
  output trn_pkg::bundle_t  bundle_o
);

  trn_pkg::mode_e mode_q, mode_d;
  logic [1:0]     verb_q, verb_d;
  logic           echo_q, echo_d;
  logic           sga_q, sga_d;
  logic           line_q, line_d;

  logic [7:0] c;
  logic       pend;
  logic [1:0] verb_off;
  logic       is_data, is_close, is_text;
  logic       e_pre, e_reply, line_mid, e_post;
  logic [7:0] reply_verb;

  assign c        = data_i.byte_in;
  assign pend     = data_i.packet_end;
  // only the low two bits of the verb offset are kept
  assign verb_off = c[1:0] - trn_pkg::TN_WILL[1:0];

  assign is_data  = (mode_q == trn_pkg::MODE_DATA);
  assign is_close = is_data && ((c == trn_pkg::TN_IAC) || (c == trn_pkg::TN_NUL));
  assign is_text  = is_data && !is_close;
  assign e_pre    = is_close && line_q;
  assign line_mid = is_text ? 1'b1 : (is_close ? 1'b0 : line_q);
  assign e_post   = pend && line_mid;

  always_comb begin
    e_reply    = 1'b0;
    reply_verb = trn_pkg::TN_WONT;
    if (mode_q == trn_pkg::MODE_OPTION) begin
      if (verb_q == trn_pkg::VERB_DO) begin
        e_reply = 1'b1;
        if ((c == trn_pkg::OPT_ECHO) || (c == trn_pkg::OPT_SGA)) begin
          reply_verb = trn_pkg::TN_WILL;
        end
      end else if (verb_q == trn_pkg::VERB_DONT) begin
        e_reply = ((c == trn_pkg::OPT_SGA) && sga_q) || ((c == trn_pkg::OPT_ECHO) && echo_q);
      end
    end
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    verb_d = verb_q;
    echo_d = echo_q;
    sga_d  = sga_q;
    line_d = line_mid;
    unique case (mode_q)
      trn_pkg::MODE_DATA: begin
        if (c == trn_pkg::TN_IAC) begin
          mode_d = trn_pkg::MODE_IAC;
        end
      end
      trn_pkg::MODE_IAC: begin
        case (c) inside
          [trn_pkg::TN_WILL:trn_pkg::TN_DONT]: begin
            verb_d = verb_off;
            mode_d = trn_pkg::MODE_OPTION;
          end
          trn_pkg::TN_SB: mode_d = trn_pkg::MODE_SUB;
          default:        mode_d = trn_pkg::MODE_DATA;
        endcase
      end
      trn_pkg::MODE_OPTION: begin
        mode_d = trn_pkg::MODE_DATA;
        if (verb_q == trn_pkg::VERB_DO) begin
          if (c == trn_pkg::OPT_SGA) begin
            sga_d = 1'b1;
          end else if (c == trn_pkg::OPT_ECHO) begin
            echo_d = 1'b1;
          end
        end else if (verb_q == trn_pkg::VERB_DONT) begin
          if ((c == trn_pkg::OPT_SGA) && sga_q) begin
            sga_d = 1'b0;
          end else if ((c == trn_pkg::OPT_ECHO) && echo_q) begin
            echo_d = 1'b0;
          end
        end
      end
      trn_pkg::MODE_SUB: begin
        if (c == trn_pkg::TN_SE) begin
          mode_d = trn_pkg::MODE_DATA;
        end
      end
      default: mode_d = trn_pkg::MODE_DATA;
    endcase
    if (pend) begin
      line_d = 1'b0;
    end
  end

  // result words
  always_comb begin
    logic [1:0] cnt;
    cnt                  = 2'd0;
    bundle_o             = '0;
    bundle_o.echo_on     = echo_d;
    bundle_o.no_go_ahead = sga_d;
    if (e_reply) begin
      bundle_o.kind[0]  = trn_pkg::KIND_REPLY;
      bundle_o.value[0] = trn_pkg::TN_IAC;
      bundle_o.kind[1]  = trn_pkg::KIND_REPLY;
      bundle_o.value[1] = reply_verb;
      bundle_o.kind[2]  = trn_pkg::KIND_REPLY;
      bundle_o.value[2] = c;
      cnt               = 2'd3;
    end else begin
      if (e_pre) begin
        bundle_o.kind[cnt]  = trn_pkg::KIND_EOL;
        bundle_o.value[cnt] = trn_pkg::TN_NUL;
        cnt                 = cnt + 2'd1;
      end
      if (is_text && echo_q) begin
        bundle_o.kind[cnt]  = trn_pkg::KIND_ECHO;
        bundle_o.value[cnt] = c;
        cnt                 = cnt + 2'd1;
      end
      if (is_text) begin
        bundle_o.kind[cnt]  = trn_pkg::KIND_TEXT;
        bundle_o.value[cnt] = c;
        cnt                 = cnt + 2'd1;
      end
      if (e_post) begin
        bundle_o.kind[cnt]  = trn_pkg::KIND_EOL;
        bundle_o.value[cnt] = trn_pkg::TN_NUL;
        cnt                 = cnt + 2'd1;
      end
    end
    bundle_o.count = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= trn_pkg::MODE_DATA;
      verb_q <= 2'd0;
      echo_q <= 1'b0;
      sga_q  <= 1'b0;
      line_q <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      verb_q <= verb_d;
      echo_q <= echo_d;
      sga_q  <= sga_d;
      line_q <= line_d;
    end
  end

endmodule

@@ design/trn_serial.sv @@
// result buffer and output register, one word per cycle while the output is not stalled
module trn_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  trn_pkg::bundle_t   bundle_i,
  output logic               stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trn_pkg::out_word_t out_data_o
);

  trn_pkg::bundle_t   b_q;
  logic               b_valid_q, b_valid_d;
  logic [1:0]         b_idx_q, b_idx_d;
  trn_pkg::out_word_t o_q, word;
  logic               o_valid_q, o_valid_d;
  logic               out_load, b_last;

  assign out_load = b_valid_q && (!o_valid_q || !out_stall_i);
  assign b_last   = ((b_idx_q + 2'd1) == b_q.count);
  // buffer frees in the same cycle its final word moves out
  assign stall_o  = b_valid_q && !(out_load && b_last);

  always_comb begin
    word.kind        = b_q.kind[b_idx_q];
    word.value       = b_q.value[b_idx_q];
    word.last        = b_last;
    word.echo_on     = b_q.echo_on;
    word.no_go_ahead = b_q.no_go_ahead;
  end

  always_comb begin
    b_valid_d = b_valid_q;
    b_idx_d   = b_idx_q;
    if (load_i) begin
      b_valid_d = (bundle_i.count != 2'd0);
      b_idx_d   = 2'd0;
    end else if (out_load) begin
      if (b_last) begin
        b_valid_d = 1'b0;
      end else begin
        b_idx_d = b_idx_q + 2'd1;
      end
    end
    if (out_load) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end else begin
      o_valid_d = o_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_idx_q   <= 2'd0;
      o_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      b_idx_q   <= b_idx_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b_q <= bundle_i;
    end
    if (out_load) begin
      o_q <= word;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

endmodule

@@ design/telnet_receive_negotiator.sv @@
// telnet receive negotiator top level
// Receive side of telnet option negotiation. Each word on the input channel
// (in_valid_i, in_stall_o, in_data_i) is one received byte plus a packet end
// flag. Each word on the output channel (out_valid_o, out_stall_i,
// out_data_o) is one result: text byte, end of command line, echo byte or
// reply byte, with last set on the final result of a received byte and the
// echo and suppress go-ahead flags as they stand after that byte.
// A byte produces zero to three result words. The byte is handled in the
// cycle it is accepted and its words sit in a three-entry buffer, from which
// one word a cycle moves into the output register while the output is not
// stalled: the first result passes through the buffer and then the output
// register. The output register is the limit: one result word per cycle
// while the output is not stalled, and bytes with no result (commands,
// subnegotiation) are taken every cycle. in_stall_o is high while the
// buffer holds words that will not all have moved out by the end of the
// cycle. A stalled output word holds; the buffer then fills and stalls the input.
// Reset puts the block in data mode with echo, suppress go-ahead and the
// pending line flag cleared, and empties both the buffer and the output.
`include "assert_macros.svh"

module telnet_receive_negotiator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  trn_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output trn_pkg::out_word_t out_data_o
);

  logic             in_fire;
  trn_pkg::bundle_t bundle;

  assign in_fire = in_valid_i && !in_stall_o;

  trn_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .data_i   (in_data_i),
    .bundle_o (bundle)
  );

  trn_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .bundle_i    (bundle),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // an echo word is always followed by its text word
  `ASSERT_NEVER(a_echo_not_last, clk_i, rst_ni,
    out_valid_o && out_data_o.last && (out_data_o.kind == trn_pkg::KIND_ECHO))

  `ASSERT_PROP(a_echo_then_text, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && (out_data_o.kind == trn_pkg::KIND_ECHO)) |=>
    (out_valid_o && (out_data_o.kind == trn_pkg::KIND_TEXT) &&
     (out_data_o.value == $past(out_data_o.value))))

  // flags do not change between the words of one received byte
  `ASSERT_PROP(a_flags_per_byte, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && !out_data_o.last) |=>
    (out_valid_o && (out_data_o.echo_on == $past(out_data_o.echo_on)) &&
     (out_data_o.no_go_ahead == $past(out_data_o.no_go_ahead))))

  `ASSERT_NEVER(a_eol_zero, clk_i, rst_ni,
    out_valid_o && (out_data_o.kind == trn_pkg::KIND_EOL) && (out_data_o.value != trn_pkg::TN_NUL))

endmodule

@@ test/tb_telnet_receive_negotiator.sv @@
// testbench for the telnet receive negotiator: directed and random bytes, checked word by word
`timescale 1ns / 1ps

module tb_telnet_receive_negotiator;

  localparam int unsigned PlanSize   = 460;
  localparam int unsigned MaxGap     = 16;
  localparam int unsigned ChokeAfter = 200;
  localparam int unsigned ChokeSpan  = 300;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned TailCycles = 20;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  trn_pkg::in_word_t  in_word = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall;
  trn_pkg::out_word_t out_word;

  trn_pkg::in_word_t  byte_plan_q[$];
  trn_pkg::out_word_t result_due_q[$];
  trn_pkg::out_word_t step_words[$];

  // own copy of the negotiation state
  trn_pkg::mode_e rx_mode = trn_pkg::MODE_DATA;
  logic [1:0]     held_verb = 2'd0;
  logic           echo_st = 1'b0;
  logic           sga_st = 1'b0;
  logic           line_open = 1'b0;

  int unsigned send_gap = 0;
  logic        send_brisk = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned rx_wait = 0;
  logic        rx_brisk = 1'b0;
  int unsigned choke_left = 0;
  logic        choke_done = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_cnt = 0;

  telnet_receive_negotiator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic put_word(input logic [1:0] k, input logic [7:0] v);
    trn_pkg::out_word_t wd;
    wd = '0;
    wd.kind = k;
    wd.value = v;
    step_words = {step_words, wd};
  endtask

  task automatic flush_line();
    if (line_open) begin
      put_word(trn_pkg::KIND_EOL, trn_pkg::TN_NUL);
      line_open = 1'b0;
    end
  endtask

  task automatic send_reply(input logic [7:0] verb, input logic [7:0] opt);
    put_word(trn_pkg::KIND_REPLY, trn_pkg::TN_IAC);
    put_word(trn_pkg::KIND_REPLY, verb);
    put_word(trn_pkg::KIND_REPLY, opt);
  endtask

  // works out the words one received byte should produce
  task automatic negotiate_byte(input trn_pkg::in_word_t w);
    trn_pkg::out_word_t wd;
    logic [7:0] b;
    b = w.byte_in;
    step_words.delete();
    case (rx_mode)
      trn_pkg::MODE_DATA: begin
        if (b == trn_pkg::TN_IAC) begin
          flush_line();
          rx_mode = trn_pkg::MODE_IAC;
        end else if (b == trn_pkg::TN_NUL) begin
          flush_line();
        end else begin
          if (echo_st) put_word(trn_pkg::KIND_ECHO, b);
          put_word(trn_pkg::KIND_TEXT, b);
          line_open = 1'b1;
        end
      end
      trn_pkg::MODE_IAC: begin
        if (b >= trn_pkg::TN_WILL && b <= trn_pkg::TN_DONT) begin
          held_verb = 2'(b - trn_pkg::TN_WILL);
          rx_mode = trn_pkg::MODE_OPTION;
        end else if (b == trn_pkg::TN_SB) begin
          rx_mode = trn_pkg::MODE_SUB;
        end else begin
          rx_mode = trn_pkg::MODE_DATA;
        end
      end
      trn_pkg::MODE_OPTION: begin
        if (held_verb == trn_pkg::VERB_DO) begin
          if (b == trn_pkg::OPT_SGA) begin
            sga_st = 1'b1;
            send_reply(trn_pkg::TN_WILL, b);
          end else if (b == trn_pkg::OPT_ECHO) begin
            echo_st = 1'b1;
            send_reply(trn_pkg::TN_WILL, b);
          end else begin
            send_reply(trn_pkg::TN_WONT, b);
          end
        end else if (held_verb == trn_pkg::VERB_DONT) begin
          if (b == trn_pkg::OPT_SGA && sga_st) begin
            sga_st = 1'b0;
            send_reply(trn_pkg::TN_WONT, b);
          end else if (b == trn_pkg::OPT_ECHO && echo_st) begin
            echo_st = 1'b0;
            send_reply(trn_pkg::TN_WONT, b);
          end
        end
        rx_mode = trn_pkg::MODE_DATA;
      end
      default: begin
        if (b == trn_pkg::TN_SE) rx_mode = trn_pkg::MODE_DATA;
      end
    endcase
    if (w.packet_end) flush_line();
    foreach (step_words[i]) begin
      wd = step_words[i];
      wd.last = (i == step_words.size() - 1);
      wd.echo_on = echo_st;
      wd.no_go_ahead = sga_st;
      result_due_q = {result_due_q, wd};
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic take_result(input trn_pkg::out_word_t got);
    trn_pkg::out_word_t want;
    if (result_due_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, got %h", $time, got);
      mismatch_cnt++;
    end else begin
      want = result_due_q.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("value", want.value, got.value);
      check_field("last", want.last, got.last);
      check_field("echo_on", want.echo_on, got.echo_on);
      check_field("no_go_ahead", want.no_go_ahead, got.no_go_ahead);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic pe);
    trn_pkg::in_word_t w;
    w.byte_in = b;
    w.packet_end = pe;
    byte_plan_q = {byte_plan_q, w};
  endtask

  function automatic logic draw_end();
    return $urandom_range(0, 7) == 0;
  endfunction

  // mostly the two options we support, sometimes anything
  function automatic logic [7:0] draw_option();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? trn_pkg::OPT_ECHO : trn_pkg::OPT_SGA;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        negotiate_byte(in_word);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_plan_q.size() != 0) begin
          in_word <= byte_plan_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= send_brisk ? 0 : $urandom_range(0, MaxGap);
          if ($urandom_range(0, 31) == 0) send_brisk <= !send_brisk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        take_result(out_word);
        rx_wait <= rx_brisk ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 31) == 0) rx_brisk <= !rx_brisk;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // one long hold-off on the output so the buffer fills and the input stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choke_left <= 0;
      choke_done <= 1'b0;
    end else if (!choke_done && bytes_taken >= ChokeAfter) begin
      choke_left <= ChokeSpan;
      choke_done <= 1'b1;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end
  end

  assign out_stall = (rx_wait != 0) || (choke_left != 0);

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout, %0d words still due", $time, result_due_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] v;
    int unsigned pick;
    int unsigned n;
    int unsigned total;

    // directed part
    push_byte(8'h41, 1'b0);
    push_byte(trn_pkg::TN_NUL, 1'b0);
    push_byte(trn_pkg::TN_NUL, 1'b1);         // packet end, no line pending
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_DO, 1'b0);
    push_byte(trn_pkg::OPT_ECHO, 1'b0);
    push_byte(8'h7F, 1'b1);                   // echo, text and line end
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_DO, 1'b0);
    push_byte(trn_pkg::OPT_SGA, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_DO, 1'b0);
    push_byte(8'h18, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_DONT, 1'b0);
    push_byte(trn_pkg::OPT_ECHO, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_DONT, 1'b0);
    push_byte(trn_pkg::OPT_ECHO, 1'b0);       // already off
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_WILL, 1'b0);
    push_byte(trn_pkg::OPT_SGA, 1'b0);
    push_byte(trn_pkg::TN_SB, 1'b0);          // plain text outside a command
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_SB, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b0);         // swallowed inside subnegotiation
    push_byte(trn_pkg::TN_SE, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b0);
    push_byte(trn_pkg::TN_IAC, 1'b1);         // command split over packets
    push_byte(trn_pkg::TN_DONT, 1'b1);
    push_byte(trn_pkg::OPT_SGA, 1'b0);

    // random part: mostly well-formed commands with random content
    while (byte_plan_q.size() < PlanSize) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(1, 254)), draw_end());
      end else if (pick < 56) begin
        push_byte(trn_pkg::TN_IAC, draw_end());
        push_byte(trn_pkg::TN_DO, draw_end());
        push_byte(draw_option(), draw_end());
      end else if (pick < 70) begin
        push_byte(trn_pkg::TN_IAC, draw_end());
        push_byte(trn_pkg::TN_DONT, draw_end());
        push_byte(draw_option(), draw_end());
      end else if (pick < 76) begin
        push_byte(trn_pkg::TN_IAC, draw_end());
        push_byte($urandom_range(0, 1) ? trn_pkg::TN_WILL : trn_pkg::TN_WONT, draw_end());
        push_byte(draw_option(), draw_end());
      end else if (pick < 83) begin
        push_byte(trn_pkg::TN_IAC, draw_end());
        push_byte(trn_pkg::TN_SB, draw_end());
        n = $urandom_range(0, 5);
        repeat (n) begin
          v = 8'($urandom_range(0, 255));
          push_byte((v == trn_pkg::TN_SE) ? trn_pkg::TN_IAC : v, draw_end());
        end
        push_byte(trn_pkg::TN_SE, draw_end());
      end else if (pick < 89) begin
        v = 8'($urandom_range(0, 255));
        if (v >= trn_pkg::TN_SB && v <= trn_pkg::TN_DONT) v = trn_pkg::TN_IAC;
        push_byte(trn_pkg::TN_IAC, draw_end());
        push_byte(v, draw_end());
      end else if (pick < 93) begin
        push_byte(trn_pkg::TN_NUL, draw_end());
      end else begin
        push_byte(8'($urandom_range(0, 255)), draw_end());
      end
    end
    total = byte_plan_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every planned byte taken and every expected word seen
    while (bytes_taken != total || result_due_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
